// ===== rtl/mtc_pkg.sv =====
// Shared types for the mixed-type numeric comparator.
// Type codes and the per-operand records passed between pipeline stages.
package mtc_pkg;

    typedef enum logic [3:0] {
        TY_I8  = 4'd0,
        TY_U8  = 4'd1,
        TY_I16 = 4'd2,
        TY_U16 = 4'd3,
        TY_I32 = 4'd4,
        TY_U32 = 4'd5,
        TY_I64 = 4'd6,
        TY_U64 = 4'd7,
        TY_FLT = 4'd8,
        TY_DBL = 4'd9
    } num_type_t;

    typedef struct packed {
        logic [63:0] bits;
        logic [3:0]  code;
    } op_raw_t;

    typedef struct packed {
        logic [63:0] norm;
        num_type_t   typ;
        logic        neg;
        logic [63:0] mag;
        logic [5:0]  lz;
    } op_prep_t;

    typedef struct packed {
        logic [63:0] norm;
        num_type_t   typ;
        logic [63:0] wide;
        logic [63:0] s64c;
        logic [63:0] u64c;
    } op_conv_t;

endpackage

// ===== rtl/mtc_req_if.sv =====
// Request channel: two tagged operands and the equal-NaNs flag.
// Depends on nothing.
interface mtc_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] operand_a;
    logic [3:0]  type_a;
    logic [63:0] operand_b;
    logic [3:0]  type_b;
    logic        equal_nans;

    modport source (output valid, operand_a, type_a, operand_b, type_b, equal_nans,
                    input ready);
    modport sink (input valid, operand_a, type_a, operand_b, type_b, equal_nans,
                  output ready);
endinterface

// ===== rtl/mtc_rsp_if.sv =====
// Response channel: less_than and equal flags.
// Depends on nothing.
interface mtc_rsp_if;
    logic valid;
    logic ready;
    logic less_than;
    logic equal;

    modport source (output valid, less_than, equal, input ready);
    modport sink (input valid, less_than, equal, output ready);
endinterface

// ===== rtl/mtc_prep.sv =====
// Operand prep: type clamp, sign/zero extension, magnitude, leading-zero count.
// Depends on mtc_pkg.
module mtc_prep
    import mtc_pkg::*;
(
    input  op_raw_t  raw,
    output op_prep_t prep
);

    num_type_t   typ;
    logic [63:0] norm;
    logic        neg;
    logic [63:0] mag;
    logic [5:0]  lz;

    always_comb
    begin
        typ = (raw.code > TY_DBL) ? TY_DBL : num_type_t'(raw.code);
        case (typ)
            TY_I8:   norm = {{56{raw.bits[7]}}, raw.bits[7:0]};
            TY_U8:   norm = {56'd0, raw.bits[7:0]};
            TY_I16:  norm = {{48{raw.bits[15]}}, raw.bits[15:0]};
            TY_U16:  norm = {48'd0, raw.bits[15:0]};
            TY_I32:  norm = {{32{raw.bits[31]}}, raw.bits[31:0]};
            TY_U32:  norm = {32'd0, raw.bits[31:0]};
            TY_FLT:  norm = {32'd0, raw.bits[31:0]};
            default: norm = raw.bits;
        endcase
        neg = (typ inside {TY_I8, TY_I16, TY_I32, TY_I64}) && norm[63];
        mag = neg ? (64'd0 - norm) : norm;
    end

    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (mag[i])
            begin
                lz = 6'(63 - i);
            end
        end
    end

    assign prep = '{norm: norm, typ: typ, neg: neg, mag: mag, lz: lz};

endmodule

// ===== rtl/mtc_convert.sv =====
// Operand conversion: widen to double bits (integers round to nearest even,
// singles exact) and truncating, saturating double-to-int64/uint64 views.
// Depends on mtc_pkg.
module mtc_convert
    import mtc_pkg::*;
(
    input  op_prep_t prep,
    output op_conv_t conv
);

    logic [63:0] sh;
    logic        rnd;
    logic [53:0] sum;
    logic [10:0] iexp;
    logic [63:0] iwide;

    logic [7:0]  fe;
    logic [22:0] fm;
    logic [4:0]  flz;
    logic [22:0] fsub;
    logic [63:0] fwide;

    logic [10:0] de;
    logic [5:0]  dk;
    logic [63:0] dmant;
    logic [63:0] dmag;
    logic        dnan;
    logic [63:0] s64c;
    logic [63:0] u64c;
    logic [63:0] wide;

    // integer to double
    always_comb
    begin
        sh   = prep.mag << prep.lz;
        rnd  = sh[10] && ((|sh[9:0]) || sh[11]);
        sum  = {1'b0, sh[63:11]} + {53'd0, rnd};
        iexp = 11'd1086 - {5'd0, prep.lz} + {10'd0, sum[53]};
        if (prep.mag == 64'd0)
        begin
            iwide = 64'd0;
        end
        else
        begin
            iwide = {prep.neg, iexp, sum[53] ? 52'd0 : sum[51:0]};
        end
    end

    // single to double
    always_comb
    begin
        fe  = prep.norm[30:23];
        fm  = prep.norm[22:0];
        flz = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (fm[i])
            begin
                flz = 5'(22 - i);
            end
        end
        fsub = fm << (flz + 5'd1);
        if (fe == 8'hFF)
        begin
            fwide = {prep.norm[31], 11'h7FF, (fm != 23'd0), fm[21:0], 29'd0};
        end
        else if (fe == 8'd0)
        begin
            if (fm == 23'd0)
            begin
                fwide = {prep.norm[31], 63'd0};
            end
            else
            begin
                fwide = {prep.norm[31], 11'd896 - {6'd0, flz}, fsub, 29'd0};
            end
        end
        else
        begin
            fwide = {prep.norm[31], {3'd0, fe} + 11'd896, fm, 29'd0};
        end
    end

    // double to saturated integers, truncating toward zero
    always_comb
    begin
        de    = prep.norm[62:52];
        dk    = 6'(de - 11'd1023);
        dnan  = (de == 11'h7FF) && (prep.norm[51:0] != 52'd0);
        dmant = {11'd0, 1'b1, prep.norm[51:0]};
        if (de < 11'd1023)
        begin
            dmag = 64'd0;
        end
        else if (dk >= 6'd52)
        begin
            dmag = dmant << (dk - 6'd52);
        end
        else
        begin
            dmag = dmant >> (6'd52 - dk);
        end

        if (dnan)
        begin
            s64c = 64'd0;
        end
        else if (!prep.norm[63] && de >= 11'd1086)
        begin
            s64c = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        else if (prep.norm[63] && (de > 11'd1086 ||
                 (de == 11'd1086 && prep.norm[51:0] != 52'd0)))
        begin
            s64c = 64'h8000_0000_0000_0000;
        end
        else
        begin
            s64c = prep.norm[63] ? (64'd0 - dmag) : dmag;
        end

        if (dnan || prep.norm[63])
        begin
            u64c = 64'd0;
        end
        else if (de >= 11'd1087)
        begin
            u64c = '1;
        end
        else
        begin
            u64c = dmag;
        end
    end

    always_comb
    begin
        case (prep.typ)
            TY_DBL:  wide = prep.norm;
            TY_FLT:  wide = fwide;
            default: wide = iwide;
        endcase
    end

    assign conv = '{norm: prep.norm, typ: prep.typ, wide: wide, s64c: s64c, u64c: u64c};

endmodule

// ===== rtl/mtc_decide.sv =====
// Final compare: native integer compare, double compare, and exact rechecks
// on ties that involve int64 or uint64.
// Depends on mtc_pkg.
module mtc_decide
    import mtc_pkg::*;
(
    input  op_conv_t ca,
    input  op_conv_t cb,
    input  logic     eqnan,
    output logic     less_than,
    output logic     equal
);

    logic        na, nb, bz;
    logic [63:0] ka, kb;
    logic        fplt, fpgt, fpeq;
    logic        lt_re, eq_re;
    logic        a_flt, b_flt;

    always_comb
    begin
        na    = (&ca.wide[62:52]) && (|ca.wide[51:0]);
        nb    = (&cb.wide[62:52]) && (|cb.wide[51:0]);
        bz    = (ca.wide[62:0] == 63'd0) && (cb.wide[62:0] == 63'd0);
        ka    = ca.wide[63] ? ~ca.wide : {1'b1, ca.wide[62:0]};
        kb    = cb.wide[63] ? ~cb.wide : {1'b1, cb.wide[62:0]};
        fplt  = !na && !nb && !bz && (ka < kb);
        fpgt  = !na && !nb && !bz && (kb < ka);
        fpeq  = !na && !nb && (bz || ca.wide == cb.wide);
        a_flt = ca.typ inside {TY_FLT, TY_DBL};
        b_flt = cb.typ inside {TY_FLT, TY_DBL};

        lt_re = 1'b0;
        eq_re = 1'b1;
        if (ca.typ == TY_U64)
        begin
            if (cb.typ == TY_I64)
            begin
                lt_re = $signed(ca.norm) < $signed(cb.norm);
                eq_re = ca.norm == cb.norm;
            end
            else if (cb.typ == TY_DBL)
            begin
                lt_re = ca.norm < cb.u64c;
                eq_re = ca.norm == cb.s64c;
            end
        end
        else if (ca.typ == TY_I64)
        begin
            if (cb.typ == TY_U64)
            begin
                lt_re = $signed(ca.norm) < $signed(cb.norm);
                eq_re = ca.norm == cb.norm;
            end
            else if (cb.typ == TY_DBL)
            begin
                lt_re = $signed(ca.norm) < $signed(cb.s64c);
                eq_re = ca.norm == cb.s64c;
            end
        end
        else if (cb.typ == TY_U64)
        begin
            if (ca.typ == TY_DBL)
            begin
                lt_re = cb.norm > ca.u64c;
                eq_re = cb.norm == ca.s64c;
            end
        end
        else if (cb.typ == TY_I64)
        begin
            if (ca.typ == TY_DBL)
            begin
                lt_re = $signed(cb.norm) > $signed(ca.s64c);
                eq_re = cb.norm == ca.s64c;
            end
        end

        if (ca.typ == cb.typ && !a_flt)
        begin
            if (ca.typ inside {TY_I8, TY_I16, TY_I32, TY_I64})
            begin
                less_than = $signed(ca.norm) < $signed(cb.norm);
            end
            else
            begin
                less_than = ca.norm < cb.norm;
            end
            equal = ca.norm == cb.norm;
        end
        else if (a_flt && b_flt)
        begin
            less_than = fplt;
            equal     = eqnan ? (ca.wide == cb.wide) : fpeq;
        end
        else
        begin
            less_than = fplt ? 1'b1 : (fpgt ? 1'b0 : lt_re);
            equal     = fpeq ? eq_re : 1'b0;
        end
    end

endmodule

// ===== rtl/mixed_type_numeric_compare.sv =====
// Mixed-type numeric comparator, top level: four-stage pipeline with handshake.
// Depends on mtc_pkg, mtc_req_if, mtc_rsp_if, mtc_prep, mtc_convert, mtc_decide.
// One item per cycle sustained while the result is taken; each accepted item passes through
// the input register, prep/leading-zero stage, rounding/conversion stage and
// result register in order. Each stage advances whenever the one after it is empty or
// moving, so a stalled result holds only the stages behind it that are full and
// req.ready stays high while any bubble remains. Only the valid flags are reset.
module mixed_type_numeric_compare
    import mtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mtc_req_if.sink     req,
    mtc_rsp_if.source   rsp
);

    logic     s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    op_raw_t  s1_a_reg, s1_b_reg;
    logic     s1_eqnan_reg, s2_eqnan_reg, s3_eqnan_reg;
    op_prep_t s2_a_reg, s2_b_reg;
    op_conv_t s3_a_reg, s3_b_reg;
    logic     lt_reg, eq_reg;

    op_prep_t prep_a, prep_b;
    op_conv_t conv_a, conv_b;
    logic     lt_next, eq_next;
    logic     en1, en2, en3, en_out;

    assign en_out = !out_valid_reg || rsp.ready;
    assign en3    = !s3_valid_reg || en_out;
    assign en2    = !s2_valid_reg || en3;
    assign en1    = !s1_valid_reg || en2;

    assign req.ready     = en1;
    assign rsp.valid     = out_valid_reg;
    assign rsp.less_than = lt_reg;
    assign rsp.equal     = eq_reg;

    mtc_prep u_prep_a (.raw(s1_a_reg), .prep(prep_a));
    mtc_prep u_prep_b (.raw(s1_b_reg), .prep(prep_b));

    mtc_convert u_conv_a (.prep(s2_a_reg), .conv(conv_a));
    mtc_convert u_conv_b (.prep(s2_b_reg), .conv(conv_b));

    mtc_decide u_decide (
        .ca        (s3_a_reg),
        .cb        (s3_b_reg),
        .eqnan     (s3_eqnan_reg),
        .less_than (lt_next),
        .equal     (eq_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= req.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_a_reg     <= '{bits: req.operand_a, code: req.type_a};
            s1_b_reg     <= '{bits: req.operand_b, code: req.type_b};
            s1_eqnan_reg <= req.equal_nans;
        end
        if (en2)
        begin
            s2_a_reg     <= prep_a;
            s2_b_reg     <= prep_b;
            s2_eqnan_reg <= s1_eqnan_reg;
        end
        if (en3)
        begin
            s3_a_reg     <= conv_a;
            s3_b_reg     <= conv_b;
            s3_eqnan_reg <= s2_eqnan_reg;
        end
        if (en_out)
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

endmodule

// ===== rtl/mtc_checker.sv =====
// Port-level checks for mixed_type_numeric_compare, attached by bind.
// Depends on the top level's req and rsp channels.
module mtc_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic less_than,
    input logic equal
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(less_than) && $stable(equal))
        else $error("stalled result changed");

    // empty output stage means the whole pipe can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("req not ready with output empty");

    // an accepted item reaches the output when the output is never stalled
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(req_valid && req_ready, 4) && $past(rst_n, 4) && $past(rst_n, 3) &&
        $past(rst_n, 2) && $past(rst_n, 1) &&
        $past(rsp_ready, 1) && $past(rsp_ready, 2) && $past(rsp_ready, 3)
        |-> rsp_valid)
        else $error("item did not arrive in four cycles");

endmodule

bind mixed_type_numeric_compare mtc_checker u_mtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .less_than (rsp.less_than),
    .equal     (rsp.equal)
);
